/* hdl/plc_pkg.sv */
// Package for the positional list store: widths, action codes and the
// per-cell control struct. No dependencies.
package plc_pkg;

	localparam int CAPACITY_DEF = 32;
	localparam int DATA_W = 32;
	localparam int LEN_W = 6;
	localparam int ACT_W = 2;

	localparam logic [ACT_W-1:0] ACT_GET = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DELETE = 2'd2;

	typedef struct packed {
		logic load;
		logic take_lower;
		logic take_upper;
	} cell_ctrl_t;

endpackage

/* hdl/plc_cell.sv */
// One storage cell of the list chain: holds one entry and takes a new value
// from the write bus or from either neighbor. Depends on plc_pkg.
module plc_cell import plc_pkg::*; (
	input  logic                     clk,
	input  cell_ctrl_t               ctrl,
	input  logic signed [DATA_W-1:0] write_value,
	input  logic signed [DATA_W-1:0] lower_value,
	input  logic signed [DATA_W-1:0] upper_value,
	output logic signed [DATA_W-1:0] value
);

	logic signed [DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			value_q <= write_value;
		end else if (ctrl.take_lower) begin
			value_q <= lower_value;
		end else if (ctrl.take_upper) begin
			value_q <= upper_value;
		end
	end

	assign value = value_q;

endmodule

/* hdl/positional_list_store_core.sv */
// Top level of the positional list store: action decode, length register,
// chain of plc_cell entries, read select and result register. Depends on plc_pkg.
//
// Channel   Direction  Handshake              Payload
// req       input      req_valid / req_stall  action, position, write_value
// rsp       output     rsp_valid / rsp_stall  status, read_value, list_length
//
// Every transfer on req is decoded and applied to the cell chain;
// one request per cycle is sustained while rsp_stall is low, limited by the single result register.
// The result appears on rsp in the cycle after the request transfer.
// A request is stalled only while a result waits with rsp_stall high.
// Reset clears the length and the result valid; entry contents stay undefined.
module positional_list_store_core import plc_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [ACT_W-1:0]         action,
	input  logic [LEN_W-1:0]         position,
	input  logic signed [DATA_W-1:0] write_value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     status,
	output logic signed [DATA_W-1:0] read_value,
	output logic [LEN_W-1:0]         list_length
);

	localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

	logic [LEN_W-1:0] count_q;
	logic rsp_valid_q;
	logic status_q;
	logic signed [DATA_W-1:0] read_value_q;
	logic [LEN_W-1:0] list_length_q;

	logic accept;
	logic in_range;
	logic get_ok;
	logic ins_ok;
	logic del_ok;
	logic op_ok;
	logic [LEN_W-1:0] index;
	logic [LEN_W-1:0] next_count;
	logic signed [DATA_W-1:0] sel_value;

	logic signed [DATA_W-1:0] cell_value [CAPACITY];
	cell_ctrl_t cell_ctrl [CAPACITY];

	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept = req_valid && !req_stall;

	assign index = position - LEN_W'(1);
	assign in_range = (position != '0) && (position <= count_q);
	assign get_ok = (action == ACT_GET) && in_range;
	assign del_ok = (action == ACT_DELETE) && in_range;
	assign ins_ok = (action == ACT_INSERT) && (count_q < CAP_L) && (position != '0)
		&& ({1'b0, position} <= ({1'b0, count_q} + (LEN_W+1)'(1)));
	assign op_ok = get_ok || ins_ok || del_ok;

	always_comb begin
		next_count = count_q;
		if (ins_ok) begin
			next_count = count_q + LEN_W'(1);
		end else if (del_ok) begin
			next_count = count_q - LEN_W'(1);
		end
	end

	always_comb begin
		sel_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (index == LEN_W'(i)) begin
				sel_value = sel_value | cell_value[i];
			end
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [LEN_W-1:0] IDX = LEN_W'(i);
		logic signed [DATA_W-1:0] lower_v;
		logic signed [DATA_W-1:0] upper_v;

		if (i == 0) begin : g_first
			assign lower_v = cell_value[i];
		end else begin : g_mid_lo
			assign lower_v = cell_value[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign upper_v = cell_value[i];
		end else begin : g_mid_hi
			assign upper_v = cell_value[i+1];
		end

		assign cell_ctrl[i].load = accept && ins_ok && (IDX == index);
		assign cell_ctrl[i].take_lower = accept && ins_ok && (IDX > index);
		assign cell_ctrl[i].take_upper = accept && del_ok && (IDX >= index);

		plc_cell u_cell (
			.clk(clk),
			.ctrl(cell_ctrl[i]),
			.write_value(write_value),
			.lower_value(lower_v),
			.upper_value(upper_v),
			.value(cell_value[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= !op_ok;
			read_value_q <= (get_ok || del_ok) ? sel_value : '0;
			list_length_q <= next_count;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status = status_q;
	assign read_value = read_value_q;
	assign list_length = list_length_q;

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid)
		else $error("A request transfer did not produce a result.");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("The list length exceeds its capacity.");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ins_ok) |=> (list_length == $past(count_q) + LEN_W'(1)) && !status)
		else $error("A good insert did not lengthen the list by one.");

	a_error_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !op_ok) |=> (count_q == $past(count_q)) && status
			&& (read_value == '0))
		else $error("A failed action changed the list or reported data.");

endmodule
